### sv/euler_camera_orientation_defines.svh
// Assertion helpers, used by the top-level module.
`ifndef EULER_CAMERA_ORIENTATION_DEFINES_SVH
`define EULER_CAMERA_ORIENTATION_DEFINES_SVH

// Condition must hold at every rising clock edge out of reset.
`define ECO_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication in the same cycle.
`define ECO_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ECO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/eco_pkg.sv
`default_nettype none
package eco_pkg;

	localparam int VECTOR_FRAC_BITS_DEF = 14;
	localparam int TRIG_ITERATIONS_DEF  = 16;

	localparam logic [15:0] SENS_RESET = 16'd6554;
	localparam logic signed [16:0] HEADING_RESET = -17'sd23040;
	localparam int HALF_TURN_Q8   = 46080;
	localparam int QUARTER_Q8     = 23040;
	localparam int FULL_TURN_Q8   = 92160;
	localparam int PITCH_LIMIT_Q8 = 22784;
	// bias that makes any heading sum positive before the modulo sweep
	localparam int WRAP_BIAS      = FULL_TURN_Q8 * 128;
	localparam int INNER_FRAC     = 30;
	localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

	typedef struct packed {
		logic signed [16:0] heading;
		logic signed [15:0] elevation;
		logic               clamped;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	// atan(2^-i) in degrees, Q.24
	function automatic logic signed [32:0] eco_atan(input logic [4:0] i);
		logic signed [32:0] r;
		case (i)
			5'd0:  r = 33'sd754974720;
			5'd1:  r = 33'sd445687602;
			5'd2:  r = 33'sd235489088;
			5'd3:  r = 33'sd119537938;
			5'd4:  r = 33'sd60000936;
			5'd5:  r = 33'sd30029717;
			5'd6:  r = 33'sd15018523;
			5'd7:  r = 33'sd7509720;
			5'd8:  r = 33'sd3754917;
			5'd9:  r = 33'sd1877466;
			5'd10: r = 33'sd938734;
			5'd11: r = 33'sd469367;
			5'd12: r = 33'sd234684;
			5'd13: r = 33'sd117342;
			5'd14: r = 33'sd58671;
			5'd15: r = 33'sd29335;
			5'd16: r = 33'sd14668;
			5'd17: r = 33'sd7334;
			5'd18: r = 33'sd3667;
			5'd19: r = 33'sd1833;
			5'd20: r = 33'sd917;
			5'd21: r = 33'sd458;
			5'd22: r = 33'sd229;
			5'd23: r = 33'sd115;
			default: r = 33'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/eco_front.sv
`default_nettype none
module eco_front import eco_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic [15:0]        sens,
	input  wire logic               full,
	output logic                    push,
	output item_t                   push_item
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_SUM  = 2'd1;
	localparam logic [1:0] F_RED  = 2'd2;
	localparam logic [1:0] F_PUSH = 2'd3;

	logic [1:0] state_q;
	logic signed [32:0] mx, my, mx_s1, my_s1;
	logic signed [24:0] incx, incy;
	logic signed [25:0] hsum, esum;
	logic [24:0] wrap_q, wrap_nx, wrap_step;
	logic [2:0] step_q;
	logic signed [16:0] heading_q;
	logic signed [15:0] elev_q;
	logic clamp_q;

	assign mx = delta_x * $signed({1'b0, sens});
	assign my = delta_y * $signed({1'b0, sens});

	// round half up, Q8 result
	assign incx = 25'((mx_s1 + 33'sd128) >>> 8);
	assign incy = 25'((my_s1 + 33'sd128) >>> 8);

	assign hsum = 26'(heading_q) + 26'(incx) + 26'(HALF_TURN_Q8) + 26'(WRAP_BIAS);
	assign esum = 26'(elev_q) + 26'(incy);

	assign wrap_step = 25'(FULL_TURN_Q8) << step_q;
	assign wrap_nx = (wrap_q >= wrap_step) ? wrap_q - wrap_step : wrap_q;

	assign in_stall = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;
	assign push_item = '{heading: heading_q, elevation: elev_q, clamped: clamp_q};

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mx_s1 <= mx;
			my_s1 <= my;
		end
		if (state_q == F_SUM) begin
			wrap_q <= hsum[24:0];
		end else if (state_q == F_RED) begin
			wrap_q <= wrap_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			step_q    <= '0;
			heading_q <= HEADING_RESET;
			elev_q    <= '0;
			clamp_q   <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) state_q <= F_SUM;
				end
				F_SUM: begin
					if (esum > 26'(PITCH_LIMIT_Q8)) begin
						elev_q  <= 16'(PITCH_LIMIT_Q8);
						clamp_q <= 1'b1;
					end else if (esum < -26'(PITCH_LIMIT_Q8)) begin
						elev_q  <= -16'(PITCH_LIMIT_Q8);
						clamp_q <= 1'b1;
					end else begin
						elev_q  <= esum[15:0];
						clamp_q <= 1'b0;
					end
					step_q  <= 3'd7;
					state_q <= F_RED;
				end
				F_RED: begin
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0) begin
						heading_q <= wrap_nx[16:0] - 17'(HALF_TURN_Q8);
						state_q   <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/eco_queue.sv
`default_nettype none
module eco_queue import eco_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  item_t     push_item,
	input  wire logic pop,
	output item_t     head,
	output qstat_t    stat
);

	item_t ent_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;

	assign head = ent_q[rd_q];
	assign stat = '{full: (cnt_q == 2'd2), empty: (cnt_q == 2'd0)};

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

### sv/eco_back.sv
`default_nettype none
module eco_back import eco_pkg::*; #(
	parameter int VECTOR_FRAC_BITS = VECTOR_FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS  = TRIG_ITERATIONS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  qstat_t             stat,
	input  item_t              head,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic signed [15:0] front_x,
	output logic signed [15:0] front_y,
	output logic signed [15:0] front_z,
	output logic signed [15:0] right_x,
	output logic signed [15:0] right_z,
	output logic signed [15:0] up_x,
	output logic signed [15:0] up_y,
	output logic signed [15:0] up_z,
	output logic signed [16:0] heading_now,
	output logic signed [15:0] elevation_now,
	output logic               elevation_clamped
);

	localparam int IW = $clog2(TRIG_ITERATIONS);
	localparam int S1 = INNER_FRAC - VECTOR_FRAC_BITS;
	localparam int S2 = 2 * INNER_FRAC - VECTOR_FRAC_BITS;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_ROT  = 2'd1;
	localparam logic [1:0] B_MUL  = 2'd2;
	localparam logic [1:0] B_OUT  = 2'd3;

	logic [1:0] state_q;
	item_t item_q;
	logic [IW-1:0] it_q;
	logic [2:0] mi_q;
	logic flip_h_q, flip_p_q;
	logic signed [32:0] xh_q, yh_q, zh_q, xp_q, yp_q, zp_q;
	logic signed [32:0] xh_nx, yh_nx, zh_nx, xp_nx, yp_nx, zp_nx;
	logic signed [32:0] atan_v;
	logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] prod_s1;
	logic signed [15:0] pv_q [4];
	logic signed [16:0] hf, pf;
	logic h_flip, p_flip;
	logic out_free;

	function automatic logic signed [15:0] clamp_vec(input logic signed [65:0] v);
		logic signed [65:0] lim;
		logic signed [65:0] r;
		lim = 66'sd1 <<< VECTOR_FRAC_BITS;
		if (v > lim) r = lim;
		else if (v < -lim) r = -lim;
		else r = v;
		return r[15:0];
	endfunction

	function automatic logic signed [15:0] vec1(input logic signed [32:0] v);
		logic signed [33:0] r;
		r = (34'(v) + (34'sd1 <<< (S1 - 1))) >>> S1;
		return clamp_vec(66'(r));
	endfunction

	// fold into [-90,90]; both sine and cosine change sign
	always_comb begin
		hf = head.heading;
		h_flip = 1'b0;
		if (head.heading > 17'sd23040) begin
			hf = head.heading - 17'(HALF_TURN_Q8);
			h_flip = 1'b1;
		end else if (head.heading < -17'sd23040) begin
			hf = head.heading + 17'(HALF_TURN_Q8);
			h_flip = 1'b1;
		end
		pf = 17'(head.elevation);
		p_flip = 1'b0;
		if (pf > 17'(QUARTER_Q8)) begin
			pf = pf - 17'(HALF_TURN_Q8);
			p_flip = 1'b1;
		end else if (pf < -17'(QUARTER_Q8)) begin
			pf = pf + 17'(HALF_TURN_Q8);
			p_flip = 1'b1;
		end
	end

	assign atan_v = eco_atan(5'(it_q));

	always_comb begin
		if (!zh_q[32]) begin
			xh_nx = xh_q - (yh_q >>> it_q);
			yh_nx = yh_q + (xh_q >>> it_q);
			zh_nx = zh_q - atan_v;
		end else begin
			xh_nx = xh_q + (yh_q >>> it_q);
			yh_nx = yh_q - (xh_q >>> it_q);
			zh_nx = zh_q + atan_v;
		end
		if (!zp_q[32]) begin
			xp_nx = xp_q - (yp_q >>> it_q);
			yp_nx = yp_q + (xp_q >>> it_q);
			zp_nx = zp_q - atan_v;
		end else begin
			xp_nx = xp_q + (yp_q >>> it_q);
			yp_nx = yp_q - (xp_q >>> it_q);
			zp_nx = zp_q + atan_v;
		end
	end

	// product order: cy*cp, sy*cp, -cy*sp, -sy*sp
	always_comb begin
		case (mi_q)
			3'd0: begin mul_a = cy_q; mul_b = 33'(cp_q); end
			3'd1: begin mul_a = sy_q; mul_b = 33'(cp_q); end
			3'd2: begin mul_a = cy_q; mul_b = -33'(sp_q); end
			3'd3: begin mul_a = sy_q; mul_b = -33'(sp_q); end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign pop = (state_q == B_IDLE) && !stat.empty;
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q   <= head;
			flip_h_q <= h_flip;
			flip_p_q <= p_flip;
			xh_q <= CORDIC_START;
			yh_q <= '0;
			zh_q <= 33'(hf) <<< 16;
			xp_q <= CORDIC_START;
			yp_q <= '0;
			zp_q <= 33'(pf) <<< 16;
		end else if (state_q == B_ROT) begin
			xh_q <= xh_nx;
			yh_q <= yh_nx;
			zh_q <= zh_nx;
			xp_q <= xp_nx;
			yp_q <= yp_nx;
			zp_q <= zp_nx;
			if (it_q == IW'(TRIG_ITERATIONS - 1)) begin
				cy_q <= flip_h_q ? 32'(-xh_nx) : 32'(xh_nx);
				sy_q <= flip_h_q ? 32'(-yh_nx) : 32'(yh_nx);
				cp_q <= flip_p_q ? 32'(-xp_nx) : 32'(xp_nx);
				sp_q <= flip_p_q ? 32'(-yp_nx) : 32'(yp_nx);
			end
		end
		if (state_q == B_MUL) begin
			prod_s1 <= mul_a * mul_b;
			if (mi_q != 3'd0) begin
				pv_q[2'(mi_q - 3'd1)] <=
					clamp_vec((66'(prod_s1) + (66'sd1 <<< (S2 - 1))) >>> S2);
			end
		end
		if (state_q == B_OUT && out_free) begin
			front_x <= pv_q[0];
			front_z <= pv_q[1];
			up_x    <= pv_q[2];
			up_z    <= pv_q[3];
			front_y <= vec1(33'(sp_q));
			right_x <= vec1(-33'(sy_q));
			right_z <= vec1(33'(cy_q));
			up_y    <= vec1(33'(cp_q));
			heading_now       <= item_q.heading;
			elevation_now     <= item_q.elevation;
			elevation_clamped <= item_q.clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			it_q      <= '0;
			mi_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						it_q    <= '0;
						state_q <= B_ROT;
					end
				end
				B_ROT: begin
					it_q <= it_q + IW'(1);
					if (it_q == IW'(TRIG_ITERATIONS - 1)) begin
						mi_q    <= '0;
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					mi_q <= mi_q + 3'd1;
					if (mi_q == 3'd4) state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### sv/euler_camera_orientation.sv
// Fly camera orientation from mouse motion.
// Input channel: in_valid / in_stall with delta_x, delta_y (signed counts).
// Output channel: out_valid / out_stall with the front, right and up vectors
// (Q1.14 by default), the new heading (Q9.8, wrapped to [-180,180)), the new
// elevation (Q8.8, limited to +/-89) and a flag set when the pitch hit the limit.
// Config: cfg_write with cfg_data loads the look sensitivity (Q0.16 deg/count);
// write only while the block is idle.
// The front registers an item, scales and sums it, then sweeps the heading
// modulo a full turn and waits for queue room; it takes no new item until it pushes.
// A two-entry queue lets the front take the next item while the back works.
// The back runs both CORDIC lanes together, then four products through one
// multiplier, then loads the output register; it pops the next item from the
// queue only after that load, which waits while the output is stalled.
// Reset: heading -90, elevation 0, sensitivity 6554, no item pending.
// A stalled output holds; the back then waits and the queue fills, after
// which in_stall stays high.
`default_nettype none
`include "euler_camera_orientation_defines.svh"
module euler_camera_orientation import eco_pkg::*; #(
	parameter int VECTOR_FRAC_BITS = VECTOR_FRAC_BITS_DEF,
	parameter int TRIG_ITERATIONS  = TRIG_ITERATIONS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] delta_x,
	input  wire logic signed [15:0] delta_y,
	input  wire logic               cfg_write,
	input  wire logic [15:0]        cfg_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      front_x,
	output logic signed [15:0]      front_y,
	output logic signed [15:0]      front_z,
	output logic signed [15:0]      right_x,
	output logic signed [15:0]      right_z,
	output logic signed [15:0]      up_x,
	output logic signed [15:0]      up_y,
	output logic signed [15:0]      up_z,
	output logic signed [16:0]      heading_now,
	output logic signed [15:0]      elevation_now,
	output logic                    elevation_clamped
);

	logic [15:0] sens_q;
	logic push, pop;
	item_t push_item, head;
	qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_RESET;
		end else if (cfg_write) begin
			sens_q <= cfg_data;
		end
	end

	eco_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.delta_x   (delta_x),
		.delta_y   (delta_y),
		.sens      (sens_q),
		.full      (qstat.full),
		.push      (push),
		.push_item (push_item)
	);

	eco_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.stat      (qstat)
	);

	eco_back #(
		.VECTOR_FRAC_BITS (VECTOR_FRAC_BITS),
		.TRIG_ITERATIONS  (TRIG_ITERATIONS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.stat              (qstat),
		.head              (head),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.front_x           (front_x),
		.front_y           (front_y),
		.front_z           (front_z),
		.right_x           (right_x),
		.right_z           (right_z),
		.up_x              (up_x),
		.up_y              (up_y),
		.up_z              (up_z),
		.heading_now       (heading_now),
		.elevation_now     (elevation_now),
		.elevation_clamped (elevation_clamped)
	);

	`ECO_ASSERT_IMPLY(a_elev_range, out_valid, (elevation_now <= 16'sd22784) && (elevation_now >= -16'sd22784), "elevation beyond limit")
	`ECO_ASSERT_IMPLY(a_clamp_at_limit, out_valid && elevation_clamped, (elevation_now == 16'sd22784) || (elevation_now == -16'sd22784), "clamp flag off limit")
	`ECO_ASSERT_IMPLY(a_head_range, out_valid, (heading_now >= -17'sd46080) && (heading_now <= 17'sd46079), "heading not wrapped")
	`ECO_ASSERT_IMPLY(a_queue_safe, qstat.full, !push && !qstat.empty, "queue overrun")

endmodule
`default_nettype wire

### bench/euler_camera_orientation_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module euler_camera_orientation_tb;
	import eco_pkg::*;

	localparam int FRAC = VECTOR_FRAC_BITS_DEF;
	localparam int ITERS = TRIG_ITERATIONS_DEF;
	localparam int N_RANDOM = 1330;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [15:0] fx, fy, fz, rx, rz, ux, uy, uz;
		logic signed [16:0] hd;
		logic signed [15:0] el;
		logic               cl;
	} pose_t;

	typedef struct {
		logic signed [15:0] dx, dy;
		bit                 typed;  // expected heading/elevation/flag read off directly
		logic signed [16:0] hd;
		logic signed [15:0] el;
		logic               cl;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] delta_x = '0;
	logic signed [15:0] delta_y = '0;
	logic cfg_write = 1'b0;
	logic [15:0] cfg_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] front_x, front_y, front_z, right_x, right_z, up_x, up_y, up_z;
	logic signed [16:0] heading_now;
	logic signed [15:0] elevation_now;
	logic elevation_clamped;

	euler_camera_orientation DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.delta_x(delta_x), .delta_y(delta_y),
		.cfg_write(cfg_write), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.front_x(front_x), .front_y(front_y), .front_z(front_z),
		.right_x(right_x), .right_z(right_z),
		.up_x(up_x), .up_y(up_y), .up_z(up_z),
		.heading_now(heading_now), .elevation_now(elevation_now),
		.elevation_clamped(elevation_clamped)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [15:0] sens_q;
	longint heading_q, elevation_q;
	pose_t pose_queue[$];
	int errors = 0;
	int n_sent = 0, n_got = 0, n_clamped = 0;
	int idle_cycles = 0;
	bit quiet_out = 1'b0;
	bit hold_out = 1'b0;
	bit timed_out = 1'b0;

	function automatic longint asr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint unit_clip(longint v);
		longint lim;
		lim = longint'(1) << FRAC;
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint one_term(longint v);
		int s;
		s = 30 - FRAC;
		return unit_clip(asr(v + (longint'(1) << (s - 1)), s));
	endfunction

	// exact product of two Q.30 terms, rounded once; operands stay below 2^31
	function automatic longint two_term(longint a, longint b);
		logic signed [95:0] p;
		int s;
		s = 60 - FRAC;
		p = 96'(signed'(a)) * 96'(signed'(b));
		p = p + (96'sd1 <<< (s - 1));
		p = p >>> s;
		return unit_clip(longint'(p));
	endfunction

	task automatic rotate(input longint ang_q8, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = ang_q8 * 65536;
		x = CORDIC_START;
		y = 0;
		flip = 1'b0;
		if (z > 90 * 64'sd16777216) begin
			z -= 180 * 64'sd16777216;
			flip = 1'b1;
		end else if (z < -90 * 64'sd16777216) begin
			z += 180 * 64'sd16777216;
			flip = 1'b1;
		end
		for (int i = 0; i < ITERS && i < 24; i++) begin
			if (z >= 0) begin
				nx = x - asr(y, i);
				y = y + asr(x, i);
				z -= longint'(eco_atan(5'(i)));
			end else begin
				nx = x + asr(y, i);
				y = y - asr(x, i);
				z += longint'(eco_atan(5'(i)));
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic advance_pose(input logic signed [15:0] dx, input logic signed [15:0] dy,
			output pose_t p);
		longint t, cy, sy, cp, sp;
		p.cl = 1'b0;
		t = heading_q + asr(longint'(dx) * longint'(sens_q) + 128, 8) + HALF_TURN_Q8;
		t = t % FULL_TURN_Q8;
		if (t < 0) t += FULL_TURN_Q8;
		heading_q = t - HALF_TURN_Q8;
		t = elevation_q + asr(longint'(dy) * longint'(sens_q) + 128, 8);
		if (t > PITCH_LIMIT_Q8) begin
			t = PITCH_LIMIT_Q8;
			p.cl = 1'b1;
		end else if (t < -PITCH_LIMIT_Q8) begin
			t = -PITCH_LIMIT_Q8;
			p.cl = 1'b1;
		end
		elevation_q = t;
		rotate(heading_q, cy, sy);
		rotate(elevation_q, cp, sp);
		p.fx = 16'(two_term(cy, cp));
		p.fy = 16'(one_term(sp));
		p.fz = 16'(two_term(sy, cp));
		p.rx = 16'(one_term(-sy));
		p.rz = 16'(one_term(cy));
		p.ux = 16'(two_term(-cy, sp));
		p.uy = 16'(one_term(cp));
		p.uz = 16'(two_term(-sy, sp));
		p.hd = 17'(heading_q);
		p.el = 16'(elevation_q);
	endtask

	// in_valid is left high on return; wait_drained drops it, as does an idle gap in the next call
	task automatic send_item(input logic signed [15:0] dx, input logic signed [15:0] dy,
			input bit idle_ok);
		pose_t p;
		while (idle_ok && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		delta_x <= dx;
		delta_y <= dy;
		do @(posedge clk); while (in_stall);
		advance_pose(dx, dy, p);
		pose_queue.push_back(p);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pose_queue.size() != 0) @(negedge clk);
		repeat (ITERS + 30) @(negedge clk);
	endtask

	task automatic load_sens(input logic [15:0] v);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		sens_q = v;
	endtask

	// receiver: random stalls, a quiet stretch, and one long hold-off
	always @(negedge clk) begin
		if (hold_out)
			out_stall <= 1'b1;
		else if (quiet_out)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 31);
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		pose_t p;
		if (arst_n && out_valid && !out_stall) begin
			n_got++;
			if (pose_queue.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				p = pose_queue.pop_front();
				check_field("front_x", p.fx, front_x);
				check_field("front_y", p.fy, front_y);
				check_field("front_z", p.fz, front_z);
				check_field("right_x", p.rx, right_x);
				check_field("right_z", p.rz, right_z);
				check_field("up_x", p.ux, up_x);
				check_field("up_y", p.uy, up_y);
				check_field("up_z", p.uz, up_z);
				check_field("heading_now", p.hd, heading_now);
				check_field("elevation_now", p.el, elevation_now);
				check_field("elevation_clamped", p.cl, elevation_clamped);
				if (p.cl) n_clamped++;
			end
		end
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("[euler_camera_orientation] ERROR");
			$finish;
		end
	end

	// directed rows; typed expectations follow from the reset state and the sensitivity
	row_t rows[$];

	task automatic add_row(input int dx, input int dy, input bit typed,
			input int hd = 0, input int el = 0, input bit cl = 0);
		row_t r;
		r.dx = 16'(dx);
		r.dy = 16'(dy);
		r.typed = typed;
		r.hd = 17'(hd);
		r.el = 16'(el);
		r.cl = cl;
		rows.push_back(r);
	endtask

	task automatic run_rows();
		pose_t p;
		foreach (rows[i]) begin
			send_item(rows[i].dx, rows[i].dy, 1'b0);
			p = pose_queue[$];
			if (rows[i].typed) begin
				check_field("table heading", rows[i].hd, p.hd);
				check_field("table elevation", rows[i].el, p.el);
				check_field("table clamped", rows[i].cl, p.cl);
			end
		end
		rows.delete();
	endtask

	initial begin
		int dx, dy;
		sens_q = SENS_RESET;
		heading_q = longint'(HEADING_RESET);
		elevation_q = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset sensitivity: zero motion leaves the reset pose
		add_row(0, 0, 1'b1, -23040, 0, 1'b0);
		add_row(1, -1, 1'b0);
		add_row(32767, 32767, 1'b0);
		add_row(-32768, -32768, 1'b0);
		add_row(-32768, 32767, 1'b0);
		run_rows();
		wait_drained();

		// unity-ish sensitivity, Q0.16 max: large steps wrap heading, saturate pitch
		load_sens(16'hFFFF);
		add_row(32767, 32767, 1'b0);
		add_row(32767, 32767, 1'b0);
		add_row(-32768, -32768, 1'b0);
		add_row(-32768, 32767, 1'b0);
		add_row(16'h5555, 16'hAAAA, 1'b0);
		add_row(16'hAAAA, 16'h5555, 1'b0);
		run_rows();
		wait_drained();

		// zero sensitivity: angles frozen at whatever they are
		load_sens(16'h0000);
		add_row(32767, -32768, 1'b0);
		add_row(-32768, 32767, 1'b0);
		run_rows();
		wait_drained();

		// sens 256 (1/256 deg per count) gives whole Q9.8 steps
		load_sens(16'd256);
		add_row(0, 0, 1'b0);
		add_row(0, 32767, 1'b0);
		add_row(0, 32767, 1'b0);
		add_row(0, -32768, 1'b0);
		add_row(0, -32768, 1'b0);
		add_row(23040, 0, 1'b0);
		add_row(23040, 0, 1'b0);
		add_row(1, 1, 1'b0);
		run_rows();
		wait_drained();

		// random phases through several sensitivities
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: load_sens(SENS_RESET);
				1: load_sens(16'(($urandom_range(65535))));
				2: load_sens(16'hFFFF);
				3: load_sens(16'(($urandom_range(255))));
				default: load_sens(16'h0001);
			endcase
			quiet_out = (phase == 2);
			for (int k = 0; k < N_RANDOM / 5; k++) begin
				// mostly mouse-sized motion, some full range
				if ($urandom_range(99) < 70) begin
					dx = $urandom_range(2000) - 1000;
					dy = $urandom_range(2000) - 1000;
				end else begin
					dx = $urandom_range(65535);
					dy = $urandom_range(65535);
				end
				if (phase == 1 && k == 40) begin
					fork
						begin
							hold_out = 1'b1;
							repeat (400) @(negedge clk);
							hold_out = 1'b0;
						end
					join_none
				end
				send_item(16'(dx), 16'(dy), (phase != 2));
			end
			wait_drained();
		end
		quiet_out = 1'b0;

		while (pose_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d motion items, checked %0d poses (%0d at the pitch limit)",
			n_sent, n_got, n_clamped);
		$display("Sensitivity swept over reset, zero, one, full scale and random values");
		if (errors == 0 && pose_queue.size() == 0) begin
			$display("[euler_camera_orientation] OK");
		end else begin
			$display("[euler_camera_orientation] ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/eco_pkg.sv
sv/eco_front.sv
sv/eco_queue.sv
sv/eco_back.sv
sv/euler_camera_orientation.sv
bench/euler_camera_orientation_tb.sv
